### rtl/core/hcpw_pkg.sv
// ----------------------------------------------------------------------------
// hcpw_pkg
// shared types, reset values and curve tables for the hilbert curve walker
// ----------------------------------------------------------------------------
package hcpw_pkg;

    localparam int ORDER_MAX_DEF  = 8;
    localparam int COORD_BITS_DEF = 10;

    localparam int ORDER_BITS = 4;
    localparam int LEN_BITS   = 6;

    localparam int CURVE_ORDER_RST = 4;
    localparam int START_X_RST     = 450;
    localparam int START_Y_RST     = 50;
    localparam int SEGMENT_LEN_RST = 10;

    localparam logic [1:0] REG_CURVE_ORDER = 2'd0;
    localparam logic [1:0] REG_START_X     = 2'd1;
    localparam logic [1:0] REG_START_Y     = 2'd2;
    localparam logic [1:0] REG_SEGMENT_LEN = 2'd3;

    typedef enum logic [1:0] {
        KIND_A = 2'd0,
        KIND_B = 2'd1,
        KIND_C = 2'd2,
        KIND_D = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    typedef struct packed {
        logic restart;
        logic advance;
    } stack_ctl_t;

    typedef struct packed {
        dir_t dir;
        logic more_cur;
        logic more_adv;
        logic order_nz;
    } stack_stat_t;

    // kind of the sub-curve that sits at child position c of a curve of kind k
    function automatic kind_t sub_kind(input kind_t k, input logic [1:0] c);
        kind_t r;
        case (c)
            2'd0:    r = kind_t'(k ^ 2'b11);
            2'd3:    r = kind_t'(k ^ 2'b01);
            default: r = k;
        endcase
        return r;
    endfunction

    // direction of the connecting segment after child c of a curve of kind k
    function automatic dir_t gap_dir(input kind_t k, input logic [1:0] c);
        dir_t r;
        r = DIR_LEFT;
        case (k)
            KIND_A:
            begin
                case (c)
                    2'd0:    r = DIR_LEFT;
                    2'd1:    r = DIR_DOWN;
                    default: r = DIR_RIGHT;
                endcase
            end
            KIND_B:
            begin
                case (c)
                    2'd0:    r = DIR_UP;
                    2'd1:    r = DIR_RIGHT;
                    default: r = DIR_DOWN;
                endcase
            end
            KIND_C:
            begin
                case (c)
                    2'd0:    r = DIR_RIGHT;
                    2'd1:    r = DIR_UP;
                    default: r = DIR_LEFT;
                endcase
            end
            default:
            begin
                case (c)
                    2'd0:    r = DIR_DOWN;
                    2'd1:    r = DIR_LEFT;
                    default: r = DIR_UP;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/core/hcpw_stack.sv
// ----------------------------------------------------------------------------
// hcpw_stack
// per-level curve kind and child position, advanced like an odometer
// ----------------------------------------------------------------------------
module hcpw_stack #(
    parameter int ORDER_MAX = hcpw_pkg::ORDER_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hcpw_pkg::stack_ctl_t                ctl,
    input  logic [hcpw_pkg::ORDER_BITS-1:0]     cfg_order,
    output hcpw_pkg::stack_stat_t               stat
);
    import hcpw_pkg::*;

    localparam int ORDER_W = $clog2(ORDER_MAX + 1);
    localparam int LVL_W   = (ORDER_MAX > 1) ? $clog2(ORDER_MAX) : 1;

    kind_t              kind_reg   [ORDER_MAX];
    kind_t              kind_next  [ORDER_MAX];
    kind_t              kind_adv   [ORDER_MAX];
    logic [1:0]         child_reg  [ORDER_MAX];
    logic [1:0]         child_next [ORDER_MAX];
    logic [1:0]         child_adv  [ORDER_MAX];
    logic [ORDER_W-1:0] run_order_reg;
    logic [ORDER_W-1:0] run_order_next;
    logic [ORDER_W-1:0] order_sat;

    logic               sel_found;
    logic [LVL_W-1:0]   sel_lvl;
    kind_t              kind_sel;
    logic [1:0]         child_sel;
    logic [1:0]         child_inc;
    kind_t              base_kind;
    logic               more_adv;

    always_comb
    begin
        if (32'(cfg_order) > ORDER_MAX)
            order_sat = ORDER_W'(ORDER_MAX);
        else
            order_sat = ORDER_W'(cfg_order);
    end

    // deepest level that still has a child to go
    always_comb
    begin
        sel_found = 1'b0;
        sel_lvl   = '0;
        for (int m = 0; m < ORDER_MAX; m++)
        begin
            if ((ORDER_W'(m) < run_order_reg) && (child_reg[m] != 2'd3))
            begin
                sel_found = 1'b1;
                sel_lvl   = LVL_W'(m);
            end
        end
    end

    assign kind_sel  = kind_reg[sel_lvl];
    assign child_sel = child_reg[sel_lvl];
    assign child_inc = child_sel + 2'd1;
    assign base_kind = sub_kind(kind_sel, child_inc);

    // levels below the stepped one restart at child zero, kinds alternate
    always_comb
    begin
        more_adv = 1'b0;
        for (int m = 0; m < ORDER_MAX; m++)
        begin
            kind_adv[m]  = kind_reg[m];
            child_adv[m] = child_reg[m];
            if (LVL_W'(m) == sel_lvl)
            begin
                child_adv[m] = child_inc;
            end
            else if (LVL_W'(m) > sel_lvl)
            begin
                child_adv[m] = 2'd0;
                if (1'(m) == sel_lvl[0])
                    kind_adv[m] = kind_t'(base_kind ^ 2'b11);
                else
                    kind_adv[m] = base_kind;
            end
            if ((ORDER_W'(m) < run_order_reg) && (child_adv[m] != 2'd3))
                more_adv = 1'b1;
        end
    end

    always_comb
    begin
        run_order_next = run_order_reg;
        for (int m = 0; m < ORDER_MAX; m++)
        begin
            kind_next[m]  = kind_reg[m];
            child_next[m] = child_reg[m];
        end
        if (ctl.restart)
        begin
            run_order_next = order_sat;
            for (int m = 0; m < ORDER_MAX; m++)
            begin
                child_next[m] = 2'd0;
                kind_next[m]  = (1'(m) == 1'b1) ? KIND_D : KIND_A;
            end
        end
        else if (ctl.advance)
        begin
            for (int m = 0; m < ORDER_MAX; m++)
            begin
                kind_next[m]  = kind_adv[m];
                child_next[m] = child_adv[m];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_order_reg <= '0;
            for (int m = 0; m < ORDER_MAX; m++)
            begin
                kind_reg[m]  <= KIND_A;
                child_reg[m] <= 2'd0;
            end
        end
        else
        begin
            run_order_reg <= run_order_next;
            for (int m = 0; m < ORDER_MAX; m++)
            begin
                kind_reg[m]  <= kind_next[m];
                child_reg[m] <= child_next[m];
            end
        end
    end

    assign stat.dir      = gap_dir(kind_sel, child_sel);
    assign stat.more_cur = sel_found;
    assign stat.more_adv = more_adv;
    assign stat.order_nz = (order_sat != '0);

endmodule

### rtl/core/hcpw_pen.sv
// ----------------------------------------------------------------------------
// hcpw_pen
// pen position and segment progress, forms the pixel of each accepted word
// ----------------------------------------------------------------------------
module hcpw_pen #(
    parameter int COORD_BITS = hcpw_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  logic                              restart,
    input  logic [COORD_BITS-1:0]             start_x,
    input  logic [COORD_BITS-1:0]             start_y,
    input  logic [hcpw_pkg::LEN_BITS-1:0]     segment_len,
    input  hcpw_pkg::stack_stat_t             stat,
    output hcpw_pkg::stack_ctl_t              ctl,
    output logic [COORD_BITS-1:0]             res_x,
    output logic [COORD_BITS-1:0]             res_y,
    output logic                              res_valid,
    output logic                              res_last
);
    import hcpw_pkg::*;

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [LEN_BITS-1:0]   seg_offset_reg, seg_offset_next;
    logic [LEN_BITS-1:0]   run_len_reg, run_len_next;
    dir_t                  seg_dir_reg, seg_dir_next;
    logic                  active_reg, active_next;

    logic                  adv;
    dir_t                  dir;
    logic [LEN_BITS-1:0]   off_left;
    logic                  more;

    assign adv      = (seg_offset_reg == '0);
    assign dir      = adv ? stat.dir : seg_dir_reg;
    assign off_left = (adv ? run_len_reg : seg_offset_reg) - LEN_BITS'(1);
    assign more     = adv ? stat.more_adv : stat.more_cur;

    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        seg_offset_next = seg_offset_reg;
        run_len_next    = run_len_reg;
        seg_dir_next    = seg_dir_reg;
        active_next     = active_reg;
        ctl             = '0;
        res_x           = '0;
        res_y           = '0;
        res_valid       = 1'b0;
        res_last        = 1'b0;

        if (fire && restart)
        begin
            ctl.restart     = 1'b1;
            cur_x_next      = start_x;
            cur_y_next      = start_y;
            seg_offset_next = '0;
            seg_dir_next    = DIR_LEFT;
            run_len_next    = (segment_len == '0) ? LEN_BITS'(1) : segment_len;
            active_next     = stat.order_nz;
            res_x           = start_x;
            res_y           = start_y;
            res_valid       = 1'b1;
            res_last        = !stat.order_nz;
        end
        else if (fire && active_reg)
        begin
            ctl.advance  = adv;
            seg_dir_next = dir;
            case (dir)
                DIR_LEFT:  cur_x_next = cur_x_reg - COORD_BITS'(1);
                DIR_DOWN:  cur_y_next = cur_y_reg + COORD_BITS'(1);
                DIR_RIGHT: cur_x_next = cur_x_reg + COORD_BITS'(1);
                default:   cur_y_next = cur_y_reg - COORD_BITS'(1);
            endcase
            seg_offset_next = off_left;
            res_last        = (off_left == '0) && !more;
            active_next     = !res_last;
            res_x           = cur_x_next;
            res_y           = cur_y_next;
            res_valid       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg      <= COORD_BITS'(START_X_RST);
            cur_y_reg      <= COORD_BITS'(START_Y_RST);
            seg_offset_reg <= '0;
            run_len_reg    <= '0;
            seg_dir_reg    <= DIR_LEFT;
            active_reg     <= 1'b0;
        end
        else
        begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            seg_offset_reg <= seg_offset_next;
            run_len_reg    <= run_len_next;
            seg_dir_reg    <= seg_dir_next;
            active_reg     <= active_next;
        end
    end

endmodule

### rtl/core/hilbert_curve_pixel_walker_top.sv
// ----------------------------------------------------------------------------
// hilbert_curve_pixel_walker_top
// walks a hilbert curve and gives one output word, a pixel coordinate while active, per accepted word
//
//   channel   signals                                    word
//   input     in_valid / in_ready                        restart
//   output    out_valid / out_ready                      pix_x pix_y pix_valid last_pixel
//   config    cfg_we, cfg_addr, cfg_data                 one register per write
//
// one word per clock while in_ready is high; each pixel is written into the output
// register as its input word is taken
// the level stack step and pen move are combinational and sit between the stack
// registers and the output register
// reset leaves the walker idle; words taken while it is idle give pix_valid 0
// in_ready drops only while the output register holds an untaken word
// ----------------------------------------------------------------------------
module hilbert_curve_pixel_walker_top #(
    parameter int ORDER_MAX  = hcpw_pkg::ORDER_MAX_DEF,
    parameter int COORD_BITS = hcpw_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [COORD_BITS-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  restart,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] pix_x,
    output logic [COORD_BITS-1:0] pix_y,
    output logic                  pix_valid,
    output logic                  last_pixel
);
    import hcpw_pkg::*;

    logic [ORDER_BITS-1:0] curve_order_reg;
    logic [COORD_BITS-1:0] start_x_reg;
    logic [COORD_BITS-1:0] start_y_reg;
    logic [LEN_BITS-1:0]   segment_len_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] pix_x_reg;
    logic [COORD_BITS-1:0] pix_y_reg;
    logic                  pix_valid_reg;
    logic                  last_pixel_reg;

    logic                  fire;
    stack_ctl_t            ctl;
    stack_stat_t           stat;
    logic [COORD_BITS-1:0] res_x;
    logic [COORD_BITS-1:0] res_y;
    logic                  res_valid;
    logic                  res_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_order_reg <= ORDER_BITS'(CURVE_ORDER_RST);
            start_x_reg     <= COORD_BITS'(START_X_RST);
            start_y_reg     <= COORD_BITS'(START_Y_RST);
            segment_len_reg <= LEN_BITS'(SEGMENT_LEN_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CURVE_ORDER: curve_order_reg <= cfg_data[ORDER_BITS-1:0];
                REG_START_X:     start_x_reg     <= cfg_data;
                REG_START_Y:     start_y_reg     <= cfg_data;
                REG_SEGMENT_LEN: segment_len_reg <= cfg_data[LEN_BITS-1:0];
                default:         ;
            endcase
        end
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    hcpw_stack #(
        .ORDER_MAX (ORDER_MAX)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cfg_order (curve_order_reg),
        .stat      (stat)
    );

    hcpw_pen #(
        .COORD_BITS (COORD_BITS)
    ) u_pen (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .restart     (restart),
        .start_x     (start_x_reg),
        .start_y     (start_y_reg),
        .segment_len (segment_len_reg),
        .stat        (stat),
        .ctl         (ctl),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_valid   (res_valid),
        .res_last    (res_last)
    );

    assign out_valid_next = fire || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pix_x_reg      <= res_x;
            pix_y_reg      <= res_y;
            pix_valid_reg  <= res_valid;
            last_pixel_reg <= res_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pix_x      = pix_x_reg;
    assign pix_y      = pix_y_reg;
    assign pix_valid  = pix_valid_reg;
    assign last_pixel = last_pixel_reg;

endmodule

### rtl/core/hcpw_checker.sv
// ----------------------------------------------------------------------------
// hcpw_checker
// port-level checks on the walker handshake and pixel words
// ----------------------------------------------------------------------------
module hcpw_checker #(
    parameter int COORD_BITS = hcpw_pkg::COORD_BITS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  restart,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [COORD_BITS-1:0] pix_x,
    input logic [COORD_BITS-1:0] pix_y,
    input logic                  pix_valid,
    input logic                  last_pixel
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pix_x) && $stable(pix_y)
            && $stable(pix_valid) && $stable(last_pixel))
        else $error("output word changed while stalled");

    // the block never stalls the input unless a word is waiting
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled with free output register");

    // a restart always gives a valid pixel word
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && restart |=> out_valid && pix_valid)
        else $error("restart word gave no pixel");

    // an empty word carries zeros
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pix_valid |-> pix_x == '0 && pix_y == '0 && !last_pixel)
        else $error("empty word not cleared");

    // after the last pixel only a restart can give another pixel
    a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pix_valid && last_pixel && in_valid && in_ready && !restart
            |=> !pix_valid)
        else $error("pixel after the last one");

endmodule

bind hilbert_curve_pixel_walker_top hcpw_checker #(
    .COORD_BITS (COORD_BITS)
) u_hcpw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .pix_valid  (pix_valid),
    .last_pixel (last_pixel)
);
